// File: design/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int CAP_BITS   = 7;
  localparam int REQ_BITS   = 3;
  localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH      = 3'd0,
    REQ_POP       = 3'd1,
    REQ_PEEK      = 3'd2,
    REQ_DUMP_DOWN = 3'd3,
    REQ_DUMP_UP   = 3'd4
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } rd_req_t;

endpackage

// File: design/bounded_lifo_stack_top.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of 32-bit words in a 64-entry RAM with registered reads.
// A request is taken when start is high and busy is low. Push, pop and peek
// leave busy low, so a new request can follow in the next cycle. Peek results
// appear on item_word/last with strobe high in the cycle after the request. A
// dump keeps busy high until its last read is issued, as the RAM read port
// yields one word per cycle; its words come out on consecutive cycles from
// the cycle after the request, the final one with last set. Each result is
// shown for exactly one cycle and must be taken then: there is no backpressure
// on the result side. Capacity is written via cfg_valid/cfg_ready/cfg_data,
// always ready, by the user only while the block is idle; it is not enforced.
module bounded_lifo_stack_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bls_pkg::REQ_BITS-1:0] req_type,
  input  logic [bls_pkg::WORD_BITS-1:0] push_word,
  output logic                         strobe,
  output logic [bls_pkg::WORD_BITS-1:0] item_word,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bls_pkg::CAP_BITS-1:0] cfg_data
);
  import bls_pkg::*;

  state_t                state, state_next;
  logic [COUNT_BITS-1:0] fill_count, fill_count_next;
  logic [CAP_BITS-1:0]   capacity;
  logic [ADDR_BITS-1:0]  ptr, ptr_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic                  dir_up, dir_up_next;
  logic                  strobe_next, last_next;

  wr_req_t               wr;
  rd_req_t               rd;

  logic                  accept;
  logic [COUNT_BITS-1:0] fill_m1;
  logic                  room;

  assign cfg_ready = 1'b1;
  assign busy      = (state == ST_DUMP);
  assign accept    = start && !busy;
  assign fill_m1   = fill_count - 1'b1;
  assign room      = (CMP_BITS'(fill_count) < CMP_BITS'(capacity)) &&
                     (CMP_BITS'(fill_count) < CMP_BITS'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    remaining <= remaining_next;
    dir_up    <= dir_up_next;
    last      <= last_next;
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    ptr_next        = ptr;
    remaining_next  = remaining;
    dir_up_next     = dir_up;
    strobe_next     = 1'b0;
    last_next       = last;
    wr.en           = 1'b0;
    wr.addr         = fill_count[ADDR_BITS-1:0];
    wr.data         = push_word;
    rd.en           = 1'b0;
    rd.addr         = fill_m1[ADDR_BITS-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_PUSH: begin
              if (room) begin
                wr.en           = 1'b1;
                fill_count_next = fill_count + 1'b1;
              end
            end
            REQ_POP: begin
              if (fill_count != '0) begin
                fill_count_next = fill_m1;
              end
            end
            REQ_PEEK: begin
              if (fill_count != '0) begin
                rd.en       = 1'b1;
                strobe_next = 1'b1;
                last_next   = 1'b1;
              end
            end
            REQ_DUMP_DOWN, REQ_DUMP_UP: begin
              if (fill_count != '0) begin
                dir_up_next    = (req_type == REQ_DUMP_UP);
                rd.en          = 1'b1;
                rd.addr        = dir_up_next ? '0 : fill_m1[ADDR_BITS-1:0];
                strobe_next    = 1'b1;
                last_next      = (fill_count == COUNT_BITS'(1));
                ptr_next       = dir_up_next ? ADDR_BITS'(1) : rd.addr - 1'b1;
                remaining_next = fill_m1;
                if (fill_count != COUNT_BITS'(1)) begin
                  state_next = ST_DUMP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        // one word per cycle; remaining counts reads still to issue
        rd.en          = 1'b1;
        rd.addr        = ptr;
        strobe_next    = 1'b1;
        last_next      = (remaining == COUNT_BITS'(1));
        ptr_next       = dir_up ? ptr + 1'b1 : ptr - 1'b1;
        remaining_next = remaining - 1'b1;
        if (remaining == COUNT_BITS'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  bls_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (item_word)
  );

  // every result comes from a stored word, so the stack cannot be empty
  assert property (@(posedge clk) disable iff (rst) strobe |-> fill_count != '0)
    else $error("result strobe with empty stack");

  assert property (@(posedge clk) disable iff (rst)
    CMP_BITS'(fill_count) <= CMP_BITS'(DEPTH))
    else $error("fill count above depth");

  assert property (@(posedge clk) disable iff (rst) busy |-> remaining != '0)
    else $error("dump running with nothing left to read");

  assert property (@(posedge clk) disable iff (rst) busy |=> strobe)
    else $error("dump cycle without a following result");

  assert property (@(posedge clk) disable iff (rst)
    busy |=> fill_count == $past(fill_count))
    else $error("fill count changed during dump");

endmodule

// File: design/bls_store.sv
`timescale 1ns / 1ps

module bls_store (
  input  logic                          clk,
  input  bls_pkg::wr_req_t              wr,
  input  bls_pkg::rd_req_t              rd,
  output logic [bls_pkg::WORD_BITS-1:0] rd_data
);
  import bls_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_SEGS    = 6;
  localparam int SEG_ITEMS   = 77;
  localparam int NUM_ROWS    = 29;
  localparam int MAX_REPORTS = 10;

  // request codes the block decodes as nothing
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } stack_word_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [REQ_BITS-1:0]  req;
    logic [WORD_BITS-1:0] data;
    row_check_t           check;
    logic [WORD_BITS-1:0] fixed_word;
    logic                 fixed_last;
  } script_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic [REQ_BITS-1:0]  req_type  = '0;
  logic [WORD_BITS-1:0] push_word = '0;
  logic                 cfg_valid = 1'b0;
  logic [CAP_BITS-1:0]  cfg_data  = '0;
  logic                 busy;
  logic                 strobe;
  logic [WORD_BITS-1:0] item_word;
  logic                 last;
  logic                 cfg_ready;

  // shadow copy of the stack
  logic [WORD_BITS-1:0] shadow_words [DEPTH];
  int                   shadow_fill = 0;
  logic [CAP_BITS-1:0]  shadow_cap  = CAP_RESET;

  stack_word_t due_words [$];
  int          error_count = 0;
  int          cycle_count = 0;

  script_row_t script [NUM_ROWS];
  int          seg_cap  [NUM_SEGS];
  int          seg_push [NUM_SEGS];
  int          seg_pop  [NUM_SEGS];

  bounded_lifo_stack_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .push_word (push_word),
    .strobe    (strobe),
    .item_word (item_word),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // applies one accepted request to the shadow stack; queues its words if asked
  function automatic void stack_apply(input logic [REQ_BITS-1:0] req,
                                      input logic [WORD_BITS-1:0] word, input bit record);
    int limit;
    limit = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    case (req)
      REQ_PUSH: begin
        if (shadow_fill < limit) begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      REQ_POP: begin
        if (shadow_fill > 0) shadow_fill--;
      end
      REQ_PEEK: begin
        if (record && shadow_fill > 0)
          due_words.push_back({shadow_words[shadow_fill-1], 1'b1});
      end
      REQ_DUMP_DOWN: begin
        if (record)
          for (int i = shadow_fill; i > 0; i--)
            due_words.push_back({shadow_words[i-1], i == 1});
      end
      REQ_DUMP_UP: begin
        if (record)
          for (int i = 0; i < shadow_fill; i++)
            due_words.push_back({shadow_words[i], i + 1 == shadow_fill});
      end
      default: ;
    endcase
  endfunction

  // holds the transaction until start meets busy low at an edge
  task automatic issue(input logic [REQ_BITS-1:0] req, input logic [WORD_BITS-1:0] word,
                       input bit record);
    start     <= 1'b1;
    req_type  <= req;
    push_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    stack_apply(req, word, record);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (due_words.size() != 0 || busy) @(posedge clk);
    // a trailing push or pop gives no word to wait for
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    shadow_cap = value;
  endtask

  always @(posedge clk) begin
    stack_word_t due;
    if (!rst && strobe) begin
      if (due_words.size() == 0) begin
        flag_error($sformatf("unexpected word %h last %b", item_word, last));
      end else begin
        due = due_words.pop_front();
        if (item_word !== due.word || last !== due.last)
          flag_error($sformatf("expected word %h last %b, got word %h last %b",
                               due.word, due.last, item_word, last));
      end
    end
  end

  initial begin
    script_row_t          row;
    int                   idle_pct;
    int                   roll;
    int                   idx;
    logic [REQ_BITS-1:0]  req;
    logic [WORD_BITS-1:0] word;

    script = '{
      '{ROW_REQ, REQ_PEEK,      32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_POP,       32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_DOWN, 32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_UP,   32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'hFFFF_FFFF, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PEEK,      32'h0000_0000, CHK_ONE,  32'hFFFF_FFFF, 1'b1},
      '{ROW_REQ, REQ_PUSH,      32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PEEK,      32'hFFFF_FFFF, CHK_ONE,  32'h0000_0000, 1'b1},
      '{ROW_REQ, REQ_PUSH,      32'hA5A5_5A5A, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_DOWN, 32'h0000_0000, CHK_PRED, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_UP,   32'h0000_0000, CHK_PRED, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_UNUSED_LO, 32'h1234_5678, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_UNUSED_HI, 32'h8765_4321, CHK_NONE, 32'h0000_0000, 1'b0},
      // capacity drops below the three stored words
      '{ROW_CFG, REQ_PUSH,      32'd2,         CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'h1234_5678, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PEEK,      32'h0000_0000, CHK_ONE,  32'hA5A5_5A5A, 1'b1},
      '{ROW_REQ, REQ_POP,       32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_POP,       32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'h0F0F_0F0F, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'hDEAD_BEEF, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_UP,   32'h0000_0000, CHK_PRED, 32'h0000_0000, 1'b0},
      '{ROW_CFG, REQ_PUSH,      32'd0,         CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_POP,       32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_POP,       32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'h0000_0001, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_DUMP_DOWN, 32'h0000_0000, CHK_NONE, 32'h0000_0000, 1'b0},
      // above the memory depth: behaves as 64
      '{ROW_CFG, REQ_PUSH,      32'd127,       CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PUSH,      32'h5555_5555, CHK_NONE, 32'h0000_0000, 1'b0},
      '{ROW_REQ, REQ_PEEK,      32'h0000_0000, CHK_ONE,  32'h5555_5555, 1'b1}
    };
    seg_cap  = '{127, 64,  0,  1,  8, 33};
    seg_push = '{ 88, 55, 15, 40, 45, 50};
    seg_pop  = '{  4, 15, 65, 40, 30, 25};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = script[r];
      if (row.kind == ROW_CFG) begin
        write_capacity(row.data[CAP_BITS-1:0]);
      end else begin
        issue(row.req, row.data, row.check == CHK_PRED);
        if (row.check == CHK_ONE) due_words.push_back({row.fixed_word, row.fixed_last});
      end
    end

    // each segment waits for the stack to go quiet, then sets a new capacity
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      write_capacity(seg_cap[seg][CAP_BITS-1:0]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        idx      = seg * SEG_ITEMS + k;
        idle_pct = (idx < 154) ? 9 : (idx < 308) ? 69 : 0;
        roll     = $urandom_range(0, 99);
        word     = $urandom;
        if (roll < seg_push[seg]) begin
          req = REQ_PUSH;
        end else if (roll < seg_push[seg] + seg_pop[seg]) begin
          req = REQ_POP;
        end else begin
          case ($urandom_range(0, 6))
            0, 1:    req = REQ_PEEK;
            2, 3:    req = REQ_DUMP_DOWN;
            4, 5:    req = REQ_DUMP_UP;
            default: req = REQ_BITS'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
          endcase
        end
        issue(req, word, 1'b1);
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
